// ===== rtl/core/tve_pkg.sv =====
package tve_pkg;

	// tag that opens the value
	localparam int unsigned TagLen = 9;
	localparam int unsigned MpW = 4;

	localparam logic [15:0] CapReset = 16'd64;

	// verdict codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	// one result beat from the scanner to the output register
	typedef struct packed {
		logic       has_byte;
		logic [7:0] value_byte;
		logic       done_res;
		status_t    status;
	} result_t;

	// characters of "vermagic=" by match position
	function automatic logic [7:0] tag_char(input logic [MpW-1:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h76;
			4'd1: c = 8'h65;
			4'd2: c = 8'h72;
			4'd3: c = 8'h6d;
			4'd4: c = 8'h61;
			4'd5: c = 8'h67;
			4'd6: c = 8'h69;
			4'd7: c = 8'h63;
			4'd8: c = 8'h3d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/tve_regs.sv =====
module tve_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] capacity
);

	logic [15:0] capacity_q;
	logic        sel_cap;

	assign sel_cap = (paddr[2] == 1'b0);
	assign pready  = 1'b1;

	// capacity register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= tve_pkg::CapReset;
		end else if (psel && penable && pwrite && sel_cap) begin
			capacity_q <= pwdata[15:0];
		end
	end

	// read back
	always_comb begin
		prdata = 32'd0;
		if (sel_cap) begin
			prdata = {16'd0, capacity_q};
		end
	end

	assign capacity = capacity_q;

endmodule

// ===== rtl/core/tve_scan.sv =====
module tve_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              end_of_data,
	input  logic [15:0]       capacity,
	input  logic              res_ready,
	output logic              res_valid,
	output tve_pkg::result_t  res
);

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_VALUE  = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam logic [tve_pkg::MpW-1:0] MpFull = tve_pkg::MpW'(tve_pkg::TagLen);

	logic                     valid_s1;
	logic [7:0]               byte_s1;
	logic                     last_s1;
	phase_t                   phase_q, phase_n;
	logic [tve_pkg::MpW-1:0]  mp_q, mp_n;
	logic [15:0]              count_q, count_n;
	logic                     advance;
	tve_pkg::result_t         res_n;
	logic                     has_res;
	logic [16:0]              count_inc;
	logic                     tag_hit;

	assign count_inc = {1'b0, count_q} + 17'd1;
	assign tag_hit   = (mp_q < MpFull) && (byte_s1 == tve_pkg::tag_char(mp_q));

	// next state and result for the beat in stage 1
	always_comb begin
		phase_n = phase_q;
		mp_n    = mp_q;
		count_n = count_q;
		has_res = 1'b0;
		res_n   = '{has_byte: 1'b0, value_byte: 8'd0, done_res: 1'b0,
			status: tve_pkg::ST_OK};
		case (phase_q)
			PH_SEARCH: begin
				if (tag_hit) begin
					mp_n = mp_q + 1'b1;
				end else begin
					mp_n = (byte_s1 == tve_pkg::tag_char('0)) ? 4'd1 : 4'd0;
				end
				if (last_s1) begin
					has_res         = 1'b1;
					res_n.done_res  = 1'b1;
					res_n.status    = (mp_n == MpFull) ? tve_pkg::ST_TRUNCATED
						: tve_pkg::ST_NOT_FOUND;
					mp_n            = '0;
				end else if (mp_n == MpFull) begin
					phase_n = PH_VALUE;
					count_n = '0;
				end
			end
			PH_VALUE: begin
				has_res        = 1'b1;
				res_n.done_res = 1'b1;
				if (byte_s1 == 8'd0) begin
					res_n.status = (count_q == 16'd0) ? tve_pkg::ST_EMPTY
						: tve_pkg::ST_OK;
					phase_n      = PH_DONE;
				end else if (count_inc >= {1'b0, capacity}) begin
					res_n.status = tve_pkg::ST_TOO_LONG;
					phase_n      = PH_DONE;
				end else begin
					count_n          = count_inc[15:0];
					res_n.has_byte   = 1'b1;
					res_n.value_byte = byte_s1;
					res_n.done_res   = last_s1;
					res_n.status     = last_s1 ? tve_pkg::ST_TRUNCATED : tve_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
		// end of frame re-arms the search
		if (last_s1) begin
			phase_n = PH_SEARCH;
			mp_n    = '0;
			count_n = '0;
		end
	end

	// a beat with no result moves on even while the output waits
	assign advance   = valid_s1 && (!has_res || res_ready);
	assign in_stall  = valid_s1 && !advance;
	assign res_valid = valid_s1 && has_res;
	assign res       = res_n;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_data;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			mp_q    <= '0;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			mp_q    <= mp_n;
			count_q <= count_n;
		end
	end

	// progress never runs past the tag length
	assert property (@(posedge clk) disable iff (!arst_n) mp_q <= MpFull)
		else $error("match progress beyond tag length");

	// while searching the count is clear
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> count_q == 16'd0)
		else $error("value count not clear while searching");

	// the value phase always holds a full tag match
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> mp_q == MpFull)
		else $error("value phase without full tag");

	// a held beat in stage 1 is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 beat lost while held");

endmodule

// ===== rtl/core/tve_out.sv =====
module tve_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  tve_pkg::result_t  res,
	output logic              res_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              has_byte,
	output logic [7:0]        value_byte,
	output logic              done_res,
	output logic [2:0]        status
);

	logic             valid_q;
	tve_pkg::result_t res_q;

	assign res_ready = !valid_q || !out_stall;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign has_byte   = res_q.has_byte;
	assign value_byte = res_q.value_byte;
	assign done_res   = res_q.done_res;
	assign status     = 3'(res_q.status);

endmodule

// ===== rtl/core/tagged_value_extractor.sv =====
// an accepted input beat passes the input register, then the result register
// throughput: one input beat per cycle while in_stall is low; beats with no result pass even
//   while a result beat waits in the output register
// reset: arst_n clears the scan state to searching and capacity to 64;
//   no clearing pass, the block takes beats right after reset
module tagged_value_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_byte,
	output logic [7:0]  value_byte,
	output logic        done_res,
	output logic [2:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]      capacity;
	logic             res_valid;
	logic             res_ready;
	tve_pkg::result_t res;

	// configuration registers
	tve_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// tag search and value extraction
	tve_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.end_of_data (end_of_data),
		.capacity    (capacity),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result register
	tve_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.has_byte   (has_byte),
		.value_byte (value_byte),
		.done_res   (done_res),
		.status     (status)
	);

endmodule

// ===== tb/tve_tb_pkg.sv =====
package tve_tb_pkg;

	// register map of the configuration port
	localparam logic [2:0] ADDR_OUT_CAPACITY = 3'd0;

	// tag bytes, first character in the top byte
	localparam logic [71:0] TAG_TEXT = "vermagic=";

	typedef enum logic [1:0] {
		SCAN_SEARCH = 2'd0,
		SCAN_VALUE  = 2'd1,
		SCAN_DONE   = 2'd2
	} scan_phase_t;

	function automatic logic [7:0] tag_byte(input int unsigned idx);
		if (idx >= tve_pkg::TagLen) return 8'h00;
		return TAG_TEXT[8*(tve_pkg::TagLen-1-idx) +: 8];
	endfunction

	// tracks the tag search and value extraction, holds the results still owed
	class extract_scoreboard;
		logic [3:0]       tag_pos;
		scan_phase_t      scan_phase;
		logic [15:0]      value_len;
		logic [15:0]      capacity;
		tve_pkg::result_t owed_results[$];
		int unsigned      bad_count;

		function new();
			capacity = tve_pkg::CapReset;
			bad_count = 0;
			rearm();
		endfunction

		function void rearm();
			tag_pos = '0;
			scan_phase = SCAN_SEARCH;
			value_len = '0;
		endfunction

		function void set_capacity(input logic [15:0] cap);
			capacity = cap;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		function int unsigned failures();
			return bad_count + owed_results.size();
		endfunction

		// work out what one accepted input beat produces
		function void note_input(input logic [7:0] b, input logic eod);
			tve_pkg::result_t r;
			bit               emit;
			r = '0;
			emit = 1'b0;
			case (scan_phase)
				SCAN_SEARCH: begin
					if (tag_pos < tve_pkg::TagLen && b == tag_byte(tag_pos))
						tag_pos = tag_pos + 4'd1;
					else
						tag_pos = (b == tag_byte(0)) ? 4'd1 : 4'd0;
					if (tag_pos >= tve_pkg::TagLen) begin
						scan_phase = SCAN_VALUE;
						value_len = '0;
					end
					if (eod) begin
						r.done_res = 1'b1;
						r.status = (scan_phase == SCAN_VALUE) ? tve_pkg::ST_TRUNCATED
							: tve_pkg::ST_NOT_FOUND;
						rearm();
						emit = 1'b1;
					end
				end
				SCAN_VALUE: begin
					emit = 1'b1;
					if (b == 8'h00) begin
						r.done_res = 1'b1;
						r.status = (value_len == 16'd0) ? tve_pkg::ST_EMPTY : tve_pkg::ST_OK;
						scan_phase = SCAN_DONE;
						if (eod) rearm();
					end else if ({1'b0, value_len} + 17'd1 >= {1'b0, capacity}) begin
						// capacity check wins over the end of the frame
						r.done_res = 1'b1;
						r.status = tve_pkg::ST_TOO_LONG;
						scan_phase = SCAN_DONE;
						if (eod) rearm();
					end else begin
						value_len = value_len + 16'd1;
						r.has_byte = 1'b1;
						r.value_byte = b;
						if (eod) begin
							r.done_res = 1'b1;
							r.status = tve_pkg::ST_TRUNCATED;
							rearm();
						end
					end
				end
				default: begin
					// verdict given, wait for the end of the frame
					if (eod) rearm();
				end
			endcase
			if (emit) owed_results.push_back(r);
		endfunction

		// compare one result beat with the oldest owed result
		function void check_result(input logic hb, input logic [7:0] vb, input logic dn,
			input logic [2:0] st);
			tve_pkg::result_t want;
			if (owed_results.size() == 0) begin
				if (bad_count < 10)
					$display("unexpected result beat: %0d %02h %0d %0d",
						hb, vb, dn, st);
				bad_count++;
				return;
			end
			want = owed_results.pop_front();
			if (hb !== want.has_byte || vb !== want.value_byte || dn !== want.done_res ||
				st !== want.status) begin
				if (bad_count < 10)
					$display("result mismatch: want %0d %02h %0d %0d, got %0d %02h %0d %0d",
						want.has_byte, want.value_byte, want.done_res, want.status,
						hb, vb, dn, st);
				bad_count++;
			end
		endfunction
	endclass

endpackage

// ===== tb/tb_tagged_value_extractor.sv =====
module tb_tagged_value_extractor;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_BEATS = 55;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        end_of_data;
	logic        out_valid;
	logic        out_stall;
	logic        has_byte;
	logic [7:0]  value_byte;
	logic        done_res;
	logic [2:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tve_tb_pkg::extract_scoreboard sb;
	logic [7:0]  frame_q[$];
	bit          calm;
	int unsigned beats_sent;
	int unsigned quiet_cycles;

	tagged_value_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_data(end_of_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.has_byte(has_byte),
		.value_byte(value_byte),
		.done_res(done_res),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver stalls at random, never during the calm phase
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 13);
	end

	// check every result beat that leaves the block
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(has_byte, value_byte, done_res, status);
	end

	// watchdog on cycles with no beat and no register access
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [7:0] b, input logic eod);
		while (!calm && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_data <= eod;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b, eod);
		beats_sent++;
	endtask

	// sender holds off until every owed result has come out
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= tve_tb_pkg::ADDR_OUT_CAPACITY;
		pwdata <= {16'($urandom()), cap};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_capacity(cap);
	endtask

	task automatic push_tag();
		for (int i = 0; i < tve_pkg::TagLen; i++) frame_q.push_back(tve_tb_pkg::tag_byte(i));
	endtask

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(0, 99) < 35)
			return tve_tb_pkg::tag_byte($urandom_range(0, tve_pkg::TagLen - 1));
		return 8'($urandom());
	endfunction

	function automatic logic [7:0] value_char();
		return 8'($urandom_range(1, 255));
	endfunction

	// send the frame, end of data on the last byte
	task automatic play_frame();
		for (int i = 0; i < frame_q.size(); i++) begin
			if ($urandom_range(0, 59) == 0) wait_results();
			send_beat(frame_q[i], i == frame_q.size() - 1);
		end
		frame_q.delete();
	endtask

	// random frame: mostly tag and value, some noise and broken frames
	task automatic build_random_frame(input logic [15:0] cap);
		int unsigned pick;
		int unsigned max_len;
		int unsigned len;
		pick = $urandom_range(0, 99);
		max_len = (cap > 16'd12) ? 12 : int'(cap) + 1;
		if (pick < 15) begin
			repeat ($urandom_range(1, 15)) frame_q.push_back(noise_byte());
			return;
		end
		if (pick < 30) begin
			// partial tag that breaks off before the real one
			for (int i = 0; i < $urandom_range(1, tve_pkg::TagLen - 1); i++)
				frame_q.push_back(tve_tb_pkg::tag_byte(i));
			frame_q.push_back(noise_byte());
		end else begin
			repeat ($urandom_range(0, 4)) frame_q.push_back(noise_byte());
		end
		push_tag();
		len = $urandom_range(0, max_len);
		repeat (len) frame_q.push_back(value_char());
		if ($urandom_range(0, 99) < 80) begin
			frame_q.push_back(8'h00);
			repeat ($urandom_range(0, 3)) frame_q.push_back(noise_byte());
		end
	endtask

	// wait for all owed results and for the block to settle
	task automatic drain();
		wait_results();
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [15:0] phase_cap[8];
		int unsigned phase_start;
		sb = new();
		calm = 1'b0;
		beats_sent = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		end_of_data <= 1'b0;
		out_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frame shorter than the tag
		frame_q.push_back(8'hFF);
		play_frame();
		// doubled first character, tag completed on the last byte
		frame_q.push_back(tve_tb_pkg::tag_byte(0));
		push_tag();
		play_frame();
		// empty value, then a byte ignored after the verdict
		push_tag();
		frame_q.push_back(8'h00);
		frame_q.push_back(8'h7F);
		play_frame();
		// value byte on the last byte
		push_tag();
		frame_q.push_back(8'h80);
		play_frame();

		phase_cap[0] = 16'd1;
		phase_cap[1] = 16'd0;
		phase_cap[2] = 16'd2;
		phase_cap[3] = 16'd5;
		phase_cap[4] = 16'hFFFF;
		phase_cap[5] = 16'd3;
		phase_cap[6] = 16'($urandom_range(6, 20));
		phase_cap[7] = 16'($urandom());

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_capacity(phase_cap[ph]);
			calm = (ph == 5);
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				build_random_frame(phase_cap[ph]);
				play_frame();
			end
		end
		calm = 1'b0;

		wait_results();
		repeat (10) @(posedge clk);
		if (sb.failures() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tve_pkg.sv
rtl/core/tve_regs.sv
rtl/core/tve_scan.sv
rtl/core/tve_out.sv
rtl/core/tagged_value_extractor.sv
tb/tve_tb_pkg.sv
tb/tb_tagged_value_extractor.sv
